// ----- hdl/srtc_pkg.sv -----
// Package: shared types, register map codes and BCD helpers for the SPI RTC block.
`timescale 1ns / 1ps
package srtc_pkg;

    localparam int SRAM_DEPTH_DEF = 256;

    localparam logic [4:0] REG_SEC      = 5'h00;
    localparam logic [4:0] REG_MIN      = 5'h01;
    localparam logic [4:0] REG_HOUR     = 5'h02;
    localparam logic [4:0] REG_WDAY     = 5'h03;
    localparam logic [4:0] REG_MDAY     = 5'h04;
    localparam logic [4:0] REG_MONTH    = 5'h05;
    localparam logic [4:0] REG_YEAR     = 5'h06;
    localparam logic [4:0] REG_A1_SEC   = 5'h07;
    localparam logic [4:0] REG_A1_MIN   = 5'h08;
    localparam logic [4:0] REG_A1_HOUR  = 5'h09;
    localparam logic [4:0] REG_A1_DAY   = 5'h0A;
    localparam logic [4:0] REG_A2_MIN   = 5'h0B;
    localparam logic [4:0] REG_A2_HOUR  = 5'h0C;
    localparam logic [4:0] REG_A2_DAY   = 5'h0D;
    localparam logic [4:0] REG_CTRL     = 5'h0E;
    localparam logic [4:0] REG_STAT     = 5'h0F;
    localparam logic [4:0] REG_AGING    = 5'h10;
    localparam logic [4:0] REG_TEMP_MSB = 5'h11;
    localparam logic [4:0] REG_TEMP_LSB = 5'h12;
    localparam logic [4:0] REG_SRAM_PTR = 5'h18;
    localparam logic [4:0] REG_SRAM_DAT = 5'h19;

    localparam logic [6:0] ADDR_CLK_END  = 7'h13;
    localparam logic [6:0] ADDR_SRAM_PTR = 7'h18;
    localparam logic [6:0] ADDR_SRAM_DAT = 7'h19;

    localparam logic [7:0] TEMP_MSB_VAL = 8'h19;
    localparam logic [7:0] TEMP_LSB_VAL = 8'h40;
    localparam logic [7:0] UNUSED_BASE  = 8'h30;
    localparam logic [4:0] CTRL_RESET   = 5'b11100;
    localparam logic [7:0] STAT_RESET   = 8'b10001000;

    typedef struct packed {
        logic       mode;
        logic       first_byte;
        logic       last_byte;
        logic [7:0] spi_byte;
        logic [5:0] now_sec;
        logic [5:0] now_min;
        logic [4:0] now_hour;
        logic [2:0] now_weekday;
        logic [4:0] now_monthday;
        logic [3:0] now_month;
        logic [7:0] now_year;
    } t_item;

    typedef struct packed {
        logic [7:0] read_byte;
        logic [1:0] alarm_flags;
    } t_result;

    typedef struct packed {
        logic       en;
        logic [7:0] data;
    } t_sram_wr;

    function automatic logic [6:0] to_bcd(input logic [6:0] v);
        logic [3:0] tens;
        logic [7:0] ones;
        logic [7:0] sum;
        tens = 4'd0;
        for (int k = 1; k <= 12; k++) begin
            if (v >= 7'(k * 10)) begin
                tens = tens + 4'd1;
            end
        end
        ones = {1'b0, v} - ({4'd0, tens} * 8'd10);
        sum  = {tens, 4'd0} + ones;
        return sum[6:0];
    endfunction

    function automatic logic [6:0] hour_code(input logic [4:0] hr, input logic twelve);
        logic       pm;
        logic [4:0] h;
        logic [6:0] b;
        logic [6:0] res;
        pm = hr > 5'd11;
        h  = pm ? hr - 5'd12 : hr;
        if (h == 5'd0) begin
            h = 5'd12;
        end
        b = to_bcd({2'b0, h});
        if (!twelve) begin
            res = to_bcd({2'b0, hr}) & 7'h3f;
        end else begin
            res = {2'b0, b[4:0]} + (pm ? 7'h60 : 7'h40);
        end
        return res;
    endfunction

endpackage

// ----- hdl/srtc_if.sv -----
// Request channel interfaces: input item and result item.
`timescale 1ns / 1ps
interface srtc_in_if;
    logic       valid;
    logic       ready;
    logic       mode;
    logic       first_byte;
    logic       last_byte;
    logic [7:0] spi_byte;
    logic [5:0] now_sec;
    logic [5:0] now_min;
    logic [4:0] now_hour;
    logic [2:0] now_weekday;
    logic [4:0] now_monthday;
    logic [3:0] now_month;
    logic [7:0] now_year;

    modport source (output valid, mode, first_byte, last_byte, spi_byte, now_sec, now_min,
                    now_hour, now_weekday, now_monthday, now_month, now_year,
                    input ready);
    modport sink (input valid, mode, first_byte, last_byte, spi_byte, now_sec, now_min,
                  now_hour, now_weekday, now_monthday, now_month, now_year,
                  output ready);
endinterface

interface srtc_out_if;
    logic       valid;
    logic       ready;
    logic [7:0] read_byte;
    logic [1:0] alarm_flags;

    modport source (output valid, read_byte, alarm_flags, input ready);
    modport sink (input valid, read_byte, alarm_flags, output ready);
endinterface

// ----- hdl/srtc_ram.sv -----
// Generic single-port-write, registered-read RAM.
`timescale 1ns / 1ps
module srtc_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 256,
    parameter int AW    = $clog2(DEPTH)
) (
    input  logic             i_clk,
    input  logic             i_we,
    input  logic [AW-1:0]    i_waddr,
    input  logic [WIDTH-1:0] i_wdata,
    input  logic             i_re,
    input  logic [AW-1:0]    i_raddr,
    output logic [WIDTH-1:0] o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_q;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_q <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_q;
endmodule

// ----- hdl/srtc_core.sv -----
// Register file, alarm match and SPI byte decode; state updates on each fired request.
`timescale 1ns / 1ps
module srtc_core #(
    parameter int SRAM_DEPTH = srtc_pkg::SRAM_DEPTH_DEF,
    parameter int AW         = $clog2(SRAM_DEPTH)
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_fire,
    input  srtc_pkg::t_item     i_item,
    input  logic [7:0]          i_sram_q,
    output srtc_pkg::t_result   o_res,
    output srtc_pkg::t_sram_wr  o_sram_wr,
    output logic [AW-1:0]       o_wr_idx,
    output logic [AW-1:0]       o_rd_idx
);
    import srtc_pkg::*;

    logic [AW-1:0] mod_tab [256];
    for (genvar g = 0; g < 256; g++) begin : g_mod
        assign mod_tab[g] = AW'(g % SRAM_DEPTH);
    end

    logic [5:0] r_sec, n_sec, r_min, n_min;
    logic [4:0] r_hour, n_hour;
    logic [2:0] r_wday, n_wday;
    logic [4:0] r_mday, n_mday;
    logic [3:0] r_month, n_month;
    logic [7:0] r_year, n_year;
    logic       r_twelve, n_twelve;
    logic [7:0] r_alarm [7];
    logic [7:0] n_alarm [7];
    logic [4:0] r_ctrl, n_ctrl;
    logic [7:0] r_stat, n_stat;
    logic [7:0] r_aging, n_aging;
    logic [7:0] r_ptr, n_ptr;
    logic [6:0] r_cmd_addr, n_cmd_addr;
    logic       r_cmd_wr, n_cmd_wr;
    logic [4:0] r_cur, n_cur;
    logic [5:0] r_cnt, n_cnt;

    logic       acc_en, acc_wr;
    logic [4:0] acc_reg;
    logic [7:0] rb;
    logic       a1, a2;
    logic [6:0] hc_new;
    logic [1:0] cent;
    logic [7:0] yrem;
    logic [3:0] ytens;
    logic [7:0] yones;
    logic [7:0] b;
    logic [AW-1:0] cur_idx;

    assign hc_new  = hour_code(i_item.now_hour, r_twelve);
    assign b       = i_item.spi_byte;
    assign cur_idx = mod_tab[r_ptr];

    always_comb begin
        cent = (r_year >= 8'd200) ? 2'd2 : (r_year >= 8'd100) ? 2'd1 : 2'd0;
        yrem = r_year - ({6'd0, cent} * 8'd100);
        ytens = 4'd0;
        for (int k = 1; k <= 9; k++) begin
            if (yrem >= 8'(k * 10)) begin
                ytens = ytens + 4'd1;
            end
        end
        yones = yrem - ({4'd0, ytens} * 8'd10);
    end

    always_comb begin
        if (r_alarm[0][7]) begin
            a1 = r_sec != i_item.now_sec;
        end else if (r_alarm[1][7]) begin
            a1 = r_alarm[0][6:0] == to_bcd({1'b0, i_item.now_sec});
        end else if (r_alarm[2][7]) begin
            a1 = r_alarm[1][6:0] == to_bcd({1'b0, i_item.now_min});
        end else if (r_alarm[3][7]) begin
            a1 = r_alarm[2][6:0] == hc_new;
        end else if (r_alarm[3][6]) begin
            a1 = r_alarm[3][5:0] == {2'b0, 4'({1'b0, i_item.now_weekday} + 4'd1)};
        end else begin
            a1 = r_alarm[3][5:0] == (to_bcd({2'b0, i_item.now_monthday}) & 7'h3f);
        end
        if (r_alarm[4][7]) begin
            a2 = r_min != i_item.now_min;
        end else if (r_alarm[5][7]) begin
            a2 = r_alarm[4][6:0] == to_bcd({1'b0, i_item.now_min});
        end else if (r_alarm[6][7]) begin
            a2 = r_alarm[5][6:0] == hc_new;
        end else if (r_alarm[6][6]) begin
            a2 = r_alarm[6][5:0] == {2'b0, 4'({1'b0, i_item.now_weekday} + 4'd1)};
        end else begin
            a2 = r_alarm[6][5:0] == (to_bcd({2'b0, i_item.now_monthday}) & 7'h3f);
        end
    end

    always_comb begin
        n_sec = r_sec; n_min = r_min; n_hour = r_hour; n_wday = r_wday;
        n_mday = r_mday; n_month = r_month; n_year = r_year; n_twelve = r_twelve;
        n_alarm = r_alarm; n_ctrl = r_ctrl; n_stat = r_stat; n_aging = r_aging;
        n_ptr = r_ptr; n_cmd_addr = r_cmd_addr; n_cmd_wr = r_cmd_wr;
        n_cur = r_cur; n_cnt = r_cnt;
        acc_en = 1'b0; acc_wr = 1'b0; acc_reg = REG_SEC; rb = 8'd0;

        if (!i_item.mode) begin
            n_sec   = i_item.now_sec;
            n_min   = i_item.now_min;
            n_hour  = i_item.now_hour;
            n_wday  = i_item.now_weekday;
            n_mday  = i_item.now_monthday;
            n_month = i_item.now_month;
            n_year  = i_item.now_year;
            n_stat  = r_stat | {6'd0, a2, a1};
        end else if (i_item.first_byte) begin
            n_cmd_addr = b[6:0];
            n_cmd_wr   = b[7];
            n_cnt      = 6'd0;
            n_cur      = 5'd0;
            if (b[6:0] < ADDR_CLK_END) begin
                n_cur = b[4:0];
                if (!b[7] && i_item.last_byte) begin
                    acc_en = 1'b1; acc_reg = b[4:0];
                end
            end else if (b[6:0] == ADDR_SRAM_PTR || b[6:0] == ADDR_SRAM_DAT) begin
                if (!b[7] && i_item.last_byte) begin
                    acc_en = 1'b1; acc_reg = b[4:0];
                end
            end else begin
                rb = UNUSED_BASE;
            end
        end else begin
            n_cnt = r_cnt + 6'd1;
            if (r_cmd_addr < ADDR_CLK_END) begin
                acc_en = 1'b1; acc_reg = r_cur; acc_wr = r_cmd_wr;
                n_cur  = (r_cur == REG_TEMP_LSB) ? REG_SEC : r_cur + 5'd1;
            end else if (r_cmd_addr == ADDR_SRAM_PTR) begin
                if (r_cur == 5'd0) begin
                    n_cur  = 5'd1;
                    acc_en = 1'b1; acc_reg = REG_SRAM_PTR; acc_wr = r_cmd_wr;
                end
            end else if (r_cmd_addr == ADDR_SRAM_DAT) begin
                acc_en = 1'b1; acc_reg = REG_SRAM_DAT; acc_wr = r_cmd_wr;
            end else begin
                rb = UNUSED_BASE + {2'b0, n_cnt};
            end
        end

        if (acc_en) begin
            unique case (acc_reg)
                REG_SEC:   rb = acc_wr ? b : {1'b0, to_bcd({1'b0, r_sec})};
                REG_MIN:   rb = acc_wr ? b : {1'b0, to_bcd({1'b0, r_min})};
                REG_HOUR: begin
                    if (acc_wr) begin
                        n_twelve = b[6];
                        rb = b;
                    end else begin
                        rb = {1'b0, hour_code(r_hour, r_twelve)};
                    end
                end
                REG_WDAY:  rb = acc_wr ? b : {5'd0, r_wday} + 8'd1;
                REG_MDAY:  rb = acc_wr ? b : {1'b0, to_bcd({2'b0, r_mday}) & 7'h3f};
                REG_MONTH: rb = acc_wr ? b :
                    {cent[0], 7'd0} + {1'b0, to_bcd(7'({3'b0, r_month} + 7'd1)) & 7'h1f};
                REG_YEAR:  rb = acc_wr ? b : {ytens, 4'd0} + yones;
                REG_A1_SEC, REG_A1_MIN, REG_A1_HOUR, REG_A1_DAY,
                REG_A2_MIN, REG_A2_HOUR, REG_A2_DAY: begin
                    if (acc_wr) begin
                        n_alarm[3'(acc_reg - REG_A1_SEC)] = b;
                        rb = b;
                    end else begin
                        rb = r_alarm[3'(acc_reg - REG_A1_SEC)];
                    end
                end
                REG_CTRL: begin
                    if (acc_wr) begin
                        n_ctrl = b[4:0];
                        rb = b;
                    end else begin
                        rb = {3'd0, r_ctrl};
                    end
                end
                REG_STAT: begin
                    if (acc_wr) begin
                        n_stat = (r_stat & 8'hf7) | (b & 8'h08);
                        if (!b[1]) n_stat[1] = 1'b0;
                        if (!b[0]) n_stat[0] = 1'b0;
                    end
                    rb = n_stat;
                end
                REG_AGING: begin
                    if (acc_wr) n_aging = b;
                    rb = acc_wr ? b : r_aging;
                end
                REG_TEMP_MSB: rb = TEMP_MSB_VAL;
                REG_TEMP_LSB: rb = TEMP_LSB_VAL;
                REG_SRAM_PTR: begin
                    if (acc_wr) n_ptr = b;
                    rb = acc_wr ? b : r_ptr;
                end
                REG_SRAM_DAT: begin
                    rb    = acc_wr ? b : i_sram_q;
                    n_ptr = (cur_idx == AW'(SRAM_DEPTH - 1)) ? 8'd0 : 8'(cur_idx) + 8'd1;
                end
                default: rb = 8'd0;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sec <= '0; r_min <= '0; r_hour <= '0; r_wday <= '0;
            r_mday <= 5'd1; r_month <= '0; r_year <= '0; r_twelve <= 1'b0;
            for (int k = 0; k < 7; k++) r_alarm[k] <= '0;
            r_ctrl <= CTRL_RESET; r_stat <= STAT_RESET; r_aging <= '0;
            r_ptr <= '0; r_cmd_addr <= '0; r_cmd_wr <= 1'b0; r_cur <= '0; r_cnt <= '0;
        end else if (i_fire) begin
            r_sec <= n_sec; r_min <= n_min; r_hour <= n_hour; r_wday <= n_wday;
            r_mday <= n_mday; r_month <= n_month; r_year <= n_year; r_twelve <= n_twelve;
            r_alarm <= n_alarm;
            r_ctrl <= n_ctrl; r_stat <= n_stat; r_aging <= n_aging;
            r_ptr <= n_ptr; r_cmd_addr <= n_cmd_addr; r_cmd_wr <= n_cmd_wr;
            r_cur <= n_cur; r_cnt <= n_cnt;
        end
    end

    assign o_res.read_byte   = rb;
    assign o_res.alarm_flags = n_stat[1:0];
    assign o_sram_wr.en      = i_fire && acc_en && acc_wr && (acc_reg == REG_SRAM_DAT);
    assign o_sram_wr.data    = b;
    assign o_wr_idx          = cur_idx;
    assign o_rd_idx          = mod_tab[i_fire ? n_ptr : r_ptr];
endmodule

// ----- hdl/spi_rtc_register_file_with_alarms.sv -----
// Top level: input register, register-file core, SRAM and result register.
//
//  channel   dir  payload                                            accepted when
//  i_in      in   mode, first/last_byte, spi_byte, now_* time        valid & ready
//  o_out     out  read_byte, alarm_flags                             valid & ready
//
// One request per cycle unless o_out stalls; registers: input, then result.
// The SRAM read is issued as a request enters the input register, with the pointer
// forwarded from the request being retired and a write-to-read bypass.
// Synchronous active-low reset clears control state; the SRAM needs no clearing pass.
// A stalled result register holds the input register; ready drops only when both are full.
`timescale 1ns / 1ps
module spi_rtc_register_file_with_alarms #(
    parameter int SRAM_DEPTH = srtc_pkg::SRAM_DEPTH_DEF
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    srtc_in_if.sink     i_in,
    srtc_out_if.source  o_out
);
    import srtc_pkg::*;

    localparam int AW = $clog2(SRAM_DEPTH);

    logic      r_sv;
    t_item     r_item;
    logic      r_ov;
    t_result   r_res;
    logic      r_byp_v;
    logic [7:0] r_byp_d;

    logic      out_free, fire, accept;
    t_result   res;
    t_sram_wr  sram_wr;
    logic [AW-1:0] wr_idx, rd_idx;
    logic [7:0] ram_q, sram_q;

    assign out_free   = !r_ov || o_out.ready;
    assign fire       = r_sv && out_free;
    assign i_in.ready = !r_sv || fire;
    assign accept     = i_in.valid && i_in.ready;
    assign sram_q     = r_byp_v ? r_byp_d : ram_q;

    srtc_core #(.SRAM_DEPTH(SRAM_DEPTH), .AW(AW)) u_core (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_fire    (fire),
        .i_item    (r_item),
        .i_sram_q  (sram_q),
        .o_res     (res),
        .o_sram_wr (sram_wr),
        .o_wr_idx  (wr_idx),
        .o_rd_idx  (rd_idx)
    );

    srtc_ram #(.WIDTH(8), .DEPTH(SRAM_DEPTH), .AW(AW)) u_sram (
        .i_clk   (i_clk),
        .i_we    (sram_wr.en),
        .i_waddr (wr_idx),
        .i_wdata (sram_wr.data),
        .i_re    (accept),
        .i_raddr (rd_idx),
        .o_rdata (ram_q)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sv    <= 1'b0;
            r_ov    <= 1'b0;
            r_byp_v <= 1'b0;
        end else begin
            if (accept) begin
                r_sv    <= 1'b1;
                r_byp_v <= sram_wr.en && (wr_idx == rd_idx);
            end else if (fire) begin
                r_sv <= 1'b0;
            end
            if (fire) begin
                r_ov <= 1'b1;
            end else if (o_out.ready) begin
                r_ov <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_byp_d             <= sram_wr.data;
            r_item.mode         <= i_in.mode;
            r_item.first_byte   <= i_in.first_byte;
            r_item.last_byte    <= i_in.last_byte;
            r_item.spi_byte     <= i_in.spi_byte;
            r_item.now_sec      <= i_in.now_sec;
            r_item.now_min      <= i_in.now_min;
            r_item.now_hour     <= i_in.now_hour;
            r_item.now_weekday  <= i_in.now_weekday;
            r_item.now_monthday <= i_in.now_monthday;
            r_item.now_month    <= i_in.now_month;
            r_item.now_year     <= i_in.now_year;
        end
        if (fire) begin
            r_res <= res;
        end
    end

    assign o_out.valid       = r_ov;
    assign o_out.read_byte   = r_res.read_byte;
    assign o_out.alarm_flags = r_res.alarm_flags;

    a_fire_fills_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        fire |=> r_ov)
        else $error("retired request did not reach result register");
    a_stall_holds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_sv && !out_free) |=> (r_sv && $stable(r_item)))
        else $error("input register lost a stalled request");
    a_ram_we_fire: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        sram_wr.en |-> fire)
        else $error("SRAM write without a retiring request");
endmodule

// ----- dv/spi_rtc_register_file_with_alarms_tb.sv -----
// Testbench: SPI RTC register file driven with random and directed requests, checked by a scoreboard.
`timescale 1ns / 1ps
module spi_rtc_register_file_with_alarms_tb;
    import srtc_pkg::*;

    localparam int DEPTH = 256;
    localparam int LIMIT = 400000;

    class rtc_scoreboard;
        logic [5:0] sec, mins;
        logic [4:0] hour;
        logic [2:0] wday;
        logic [4:0] mday;
        logic [3:0] month;
        logic [7:0] year;
        logic       twelve;
        logic [7:0] alarm[7];
        logic [4:0] ctrl;
        logic [7:0] stat, aging, ptr;
        logic [7:0] sram[DEPTH];
        logic [6:0] caddr;
        logic       cwr;
        logic [4:0] creg;
        logic [5:0] bcnt;
        t_result    pending[$];
        int         errors;

        function new();
            sec = 0; mins = 0; hour = 0; wday = 0; mday = 1; month = 0; year = 0;
            twelve = 0;
            foreach (alarm[k]) alarm[k] = 0;
            ctrl = CTRL_RESET; stat = STAT_RESET; aging = 0; ptr = 0;
            foreach (sram[k]) sram[k] = 0;
            caddr = 0; cwr = 0; creg = 0; bcnt = 0; errors = 0;
        endfunction

        function logic [7:0] bcd(int v);
            return 8'((((v / 10) << 4) + v % 10) & 8'h7f);
        endfunction

        function logic [7:0] hcode();
            int h;
            bit pm;
            h = hour;
            if (!twelve) return bcd(h) & 8'h3f;
            pm = h > 11;
            if (pm) h -= 12;
            if (h == 0) h = 12;
            return (bcd(h) & 8'h1f) + (pm ? 8'h60 : 8'h40);
        endfunction

        function bit tail_hit(logic [7:0] hr, logic [7:0] dd);
            if (dd[7]) return (hr & 8'h7f) == hcode();
            if (dd[6]) return (dd & 8'h3f) == wday + 1;
            return (dd & 8'h3f) == (bcd(mday) & 8'h3f);
        endfunction

        function logic [7:0] reg_access(logic [4:0] r, bit wr, logic [7:0] d);
            logic [7:0] v;
            case (r)
                REG_SEC: return wr ? d : bcd(sec);
                REG_MIN: return wr ? d : bcd(mins);
                REG_HOUR: begin
                    if (wr) begin
                        twelve = d[6];
                        return d;
                    end
                    return hcode();
                end
                REG_WDAY: return wr ? d : 8'(wday + 1);
                REG_MDAY: return wr ? d : bcd(mday) & 8'h3f;
                REG_MONTH: return wr ? d :
                    8'((((year / 100) & 1) << 7) + (bcd(month + 1) & 8'h1f));
                REG_YEAR: return wr ? d : 8'((((year % 100) / 10) << 4) + year % 10);
                REG_A1_SEC, REG_A1_MIN, REG_A1_HOUR, REG_A1_DAY,
                REG_A2_MIN, REG_A2_HOUR, REG_A2_DAY: begin
                    if (wr) alarm[r - REG_A1_SEC] = d;
                    return alarm[r - REG_A1_SEC];
                end
                REG_CTRL: begin
                    if (wr) begin
                        ctrl = d[4:0];
                        return d;
                    end
                    return 8'(ctrl);
                end
                REG_STAT: begin
                    if (wr) begin
                        stat = (stat & 8'hf7) | (d & 8'h08);
                        if (!d[1]) stat[1] = 0;
                        if (!d[0]) stat[0] = 0;
                    end
                    return stat;
                end
                REG_AGING: begin
                    if (wr) aging = d;
                    return aging;
                end
                REG_TEMP_MSB: return TEMP_MSB_VAL;
                REG_TEMP_LSB: return TEMP_LSB_VAL;
                REG_SRAM_PTR: begin
                    if (wr) ptr = d;
                    return ptr;
                end
                REG_SRAM_DAT: begin
                    v = d;
                    if (wr) sram[ptr] = d;
                    else v = sram[ptr];
                    ptr = ptr + 8'd1;
                    return v;
                end
                default: return 0;
            endcase
        endfunction

        function void note_request(t_item it);
            logic [7:0] r;
            logic [5:0] osec, omin;
            bit a1, a2;
            r = 0;
            if (!it.mode) begin
                osec = sec; omin = mins;
                sec = it.now_sec; mins = it.now_min; hour = it.now_hour;
                wday = it.now_weekday; mday = it.now_monthday;
                month = it.now_month; year = it.now_year;
                if (alarm[0][7]) a1 = osec != sec;
                else if (alarm[1][7]) a1 = (alarm[0] & 8'h7f) == bcd(sec);
                else if (alarm[2][7]) a1 = (alarm[1] & 8'h7f) == bcd(mins);
                else a1 = tail_hit(alarm[2], alarm[3]);
                if (alarm[4][7]) a2 = omin != mins;
                else if (alarm[5][7]) a2 = (alarm[4] & 8'h7f) == bcd(mins);
                else a2 = tail_hit(alarm[5], alarm[6]);
                if (a1) stat[0] = 1;
                if (a2) stat[1] = 1;
            end else if (it.first_byte) begin
                caddr = it.spi_byte[6:0]; cwr = it.spi_byte[7]; bcnt = 0; creg = 0;
                if (caddr < ADDR_CLK_END) begin
                    creg = caddr[4:0];
                    if (!cwr && it.last_byte) r = reg_access(caddr[4:0], 0, it.spi_byte);
                end else if (caddr == ADDR_SRAM_PTR || caddr == ADDR_SRAM_DAT) begin
                    if (!cwr && it.last_byte) r = reg_access(caddr[4:0], 0, it.spi_byte);
                end else r = UNUSED_BASE;
            end else begin
                bcnt = bcnt + 6'd1;
                if (caddr < ADDR_CLK_END) begin
                    r = reg_access(creg, cwr, it.spi_byte);
                    creg = (creg == 5'h12) ? 5'h00 : creg + 5'd1;
                end else if (caddr == ADDR_SRAM_PTR) begin
                    if (creg == 0) begin
                        creg = 5'd1;
                        r = reg_access(REG_SRAM_PTR, cwr, it.spi_byte);
                    end
                end else if (caddr == ADDR_SRAM_DAT) r = reg_access(REG_SRAM_DAT, cwr, it.spi_byte);
                else r = UNUSED_BASE + 8'(bcnt);
            end
            pending.push_back('{read_byte: r, alarm_flags: stat[1:0]});
        endfunction

        function void check_result(t_result got);
            t_result exp_r;
            if (pending.size() == 0) begin
                $error("unexpected result read_byte=%0h", got.read_byte);
                errors++;
                return;
            end
            exp_r = pending.pop_front();
            if (got.read_byte !== exp_r.read_byte) begin
                $error("read_byte expected %0h actual %0h", exp_r.read_byte, got.read_byte);
                errors++;
            end
            if (got.alarm_flags !== exp_r.alarm_flags) begin
                $error("alarm_flags expected %0h actual %0h", exp_r.alarm_flags,
                       got.alarm_flags);
                errors++;
            end
        endfunction
    endclass

    logic i_clk = 0;
    logic i_rst_n = 0;
    srtc_in_if  in_ch();
    srtc_out_if out_ch();
    rtc_scoreboard sb;
    int send_idle = 0, recv_idle = 0;
    int cycles = 0;
    bit sram_valid[DEPTH];
    logic [7:0] ptr_mirror;

    spi_rtc_register_file_with_alarms u_top (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_in(in_ch.sink), .o_out(out_ch.source)
    );

    always begin
        #5 i_clk = 1;
        #5 i_clk = 0;
    end

    always @(posedge i_clk) begin
        cycles++;
        if (cycles > LIMIT) begin
            $display("spi_rtc_register_file_with_alarms_tb: errors");
            $finish;
        end
        if (i_rst_n && out_ch.valid && out_ch.ready)
            sb.check_result('{read_byte: out_ch.read_byte, alarm_flags: out_ch.alarm_flags});
    end

    always @(negedge i_clk) out_ch.ready <= ($urandom_range(99) >= recv_idle);

    task automatic send(t_item it);
        while ($urandom_range(99) < send_idle) begin
            in_ch.valid <= 0;
            @(negedge i_clk);
        end
        in_ch.valid <= 1;
        in_ch.mode <= it.mode; in_ch.first_byte <= it.first_byte;
        in_ch.last_byte <= it.last_byte; in_ch.spi_byte <= it.spi_byte;
        in_ch.now_sec <= it.now_sec; in_ch.now_min <= it.now_min;
        in_ch.now_hour <= it.now_hour; in_ch.now_weekday <= it.now_weekday;
        in_ch.now_monthday <= it.now_monthday; in_ch.now_month <= it.now_month;
        in_ch.now_year <= it.now_year;
        do @(posedge i_clk); while (!in_ch.ready);
        sb.note_request(it);
        @(negedge i_clk);
    endtask

    function automatic t_item random_time();
        t_item it;
        it = t_item'({$urandom, $urandom});
        it.mode = 0;
        it.now_sec = 6'($urandom_range(59)); it.now_min = 6'($urandom_range(59));
        it.now_hour = 5'($urandom_range(23)); it.now_weekday = 3'($urandom_range(6));
        it.now_monthday = 5'($urandom_range(31, 1)); it.now_month = 4'($urandom_range(11));
        it.now_year = 8'($urandom_range(199));
        return it;
    endfunction

    task automatic spi(logic first, logic last, logic [7:0] b);
        t_item it;
        it = random_time();
        it.mode = 1; it.first_byte = first; it.last_byte = last; it.spi_byte = b;
        send(it);
    endtask

    // transfer: command then n data bytes; SRAM reads kept on written entries
    task automatic transfer(logic [7:0] cmd, int n);
        logic [7:0] d;
        if (cmd[6:0] == ADDR_SRAM_DAT && !cmd[7]) begin
            for (int k = 0; k <= n; k++)
                if (!sram_valid[8'(ptr_mirror + k)]) cmd[7] = 1;
        end
        spi(1, n == 0, cmd);
        for (int k = 0; k < n; k++) begin
            d = 8'($urandom);
            if (cmd[6:0] == ADDR_SRAM_DAT && cmd[7]) sram_valid[ptr_mirror] = 1;
            spi(0, k == n - 1, d);
            if (cmd[6:0] == ADDR_SRAM_DAT) ptr_mirror++;
            if (cmd[6:0] == ADDR_SRAM_PTR && k == 0 && cmd[7]) ptr_mirror = d;
        end
        if (cmd[6:0] == ADDR_SRAM_DAT && !cmd[7] && n == 0) ptr_mirror++;
    endtask

    task automatic run_phase(int n);
        int sel;
        logic [7:0] cmd;
        for (int k = 0; k < n; ) begin
            sel = $urandom_range(99);
            if (sel < 20) begin
                send(random_time());
                k++;
            end else begin
                if (sel < 45) cmd = {1'($urandom), 7'($urandom_range(18))};
                else if (sel < 55) cmd = 8'({1'b1, 2'b0, REG_A1_SEC} + $urandom_range(6));
                else if (sel < 65) cmd = {1'($urandom), ADDR_SRAM_PTR};
                else if (sel < 85) cmd = {1'($urandom), ADDR_SRAM_DAT};
                else cmd = 8'($urandom);
                sel = $urandom_range(4) == 0 ? $urandom_range(24) : $urandom_range(3);
                transfer(cmd, sel);
                k += sel + 1;
            end
        end
    endtask

    initial begin
        t_item it;
        sb = new();
        in_ch.valid = 0; in_ch.mode = 0; in_ch.first_byte = 0; in_ch.last_byte = 0;
        in_ch.spi_byte = 0; in_ch.now_sec = 0; in_ch.now_min = 0; in_ch.now_hour = 0;
        in_ch.now_weekday = 0; in_ch.now_monthday = 1; in_ch.now_month = 0;
        in_ch.now_year = 0; out_ch.ready = 0;
        ptr_mirror = 0;
        repeat (10) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1;
        @(negedge i_clk);

        // directed: reads after reset, time extremes, 12-hour mode, alarms, status, SRAM wrap
        transfer({1'b0, 7'h00}, 19);
        transfer({1'b0, 7'h11}, 0);
        it = random_time(); it.now_sec = 59; it.now_min = 59; it.now_hour = 23;
        it.now_weekday = 6; it.now_monthday = 31; it.now_month = 11; it.now_year = 199;
        send(it);
        transfer({1'b0, 7'h00}, 7);
        spi(1, 0, {1'b1, 7'h02}); spi(0, 1, 8'h40);
        for (int h = 0; h < 24; h += 11) begin
            it = random_time(); it.now_hour = 5'(h); send(it);
            transfer({1'b0, 7'h02}, 0);
        end
        spi(1, 0, {1'b1, 7'h07}); spi(0, 0, 8'h80); spi(0, 0, 8'h00); spi(0, 0, 8'h00);
        spi(0, 0, 8'h00); spi(0, 1, 8'h80);
        send(random_time());
        spi(1, 0, {1'b1, 7'h0F}); spi(0, 1, 8'hFC);
        spi(1, 0, {1'b1, ADDR_SRAM_PTR}); spi(0, 1, 8'hFF);
        ptr_mirror = 8'hFF;
        transfer({1'b1, ADDR_SRAM_DAT}, 2);
        spi(1, 0, {1'b1, 7'h7F}); spi(0, 1, 8'h00);
        spi(0, 1, 8'hA5);

        send_idle = 11; recv_idle = 56;
        run_phase(470);
        send_idle = 56; recv_idle = 11;
        run_phase(470);
        send_idle = 0; recv_idle = 0;
        run_phase(470);
        in_ch.valid <= 0;

        while (sb.pending.size() != 0) @(posedge i_clk);
        repeat (20) @(posedge i_clk);
        if (sb.errors == 0 && sb.pending.size() == 0)
            $display("spi_rtc_register_file_with_alarms_tb: clean");
        else
            $display("spi_rtc_register_file_with_alarms_tb: errors");
        $finish;
    end
endmodule
